### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files; they expect clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an expression is never true.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_PROP(label, !(expr), msg)

`endif

### rtl/core/stt_pkg.sv
// Package for the text tokenizer: widths, payload types, byte codes, comment modes, queue sizes, classes.
package stt_pkg;

  localparam int OffsetWidth = 24;
  localparam int LineWidth   = 20;
  localparam int ColumnWidth = 16;

  typedef logic [OffsetWidth-1:0] off_t;
  typedef logic [LineWidth-1:0]   line_t;
  typedef logic [ColumnWidth-1:0] col_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    off_t  token_start;
    off_t  token_end;
    line_t token_line;
    col_t  token_column;
    logic  run_last;
  } out_item_t;

  // Byte codes
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;

  // Comment mode codes
  localparam logic [1:0] ModeNone  = 2'd0;
  localparam logic [1:0] ModeLine  = 2'd1;
  localparam logic [1:0] ModeBlock = 2'd2;

  // Result queue
  localparam int FifoDepth  = 4;
  localparam int PtrWidth   = $clog2(FifoDepth);
  localparam int CountWidth = $clog2(FifoDepth + 1);

  function automatic logic is_word(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || (c == ChUnder);
  endfunction

  function automatic logic is_break(input logic [7:0] c);
    return (c == ChCr) || (c == ChLf);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || is_break(c);
  endfunction

endpackage

### rtl/core/schema_text_tokenizer_top.sv
// Streaming tokenizer top level: lexer state, token result queue and handshakes.
//
// Takes one text byte per beat and reports token boundaries (start and end offset,
// start line and column). A byte is judged when the next one arrives, so a token is
// reported with the byte after its last byte, or on the final beat; a block comment
// is reported with its closing slash. Each beat is judged in a single pass of
// byte-class and compare logic that updates the lexer state, and the zero, one or
// two tokens it yields go into a four-entry result queue that drains one token per
// cycle while out_ready_i is high. Input is taken while the queue has room for two
// tokens, so the block sustains one byte per cycle as long as tokens are drained as
// fast as they arrive. Counters saturate; lexer state resets after the final byte.
`include "assert_macros.svh"

module schema_text_tokenizer_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  stt_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output stt_pkg::out_item_t   out_data_o
);

  // Lexer state
  logic [7:0]     held_q, held_d;
  logic           held_valid_q, held_valid_d;
  logic           drop_next_q, drop_next_d;
  stt_pkg::off_t  offset_q, offset_d;
  stt_pkg::line_t line_q, line_d;
  stt_pkg::col_t  column_q, column_d;
  logic           open_q, open_d;
  logic [1:0]     mode_q, mode_d;
  stt_pkg::off_t  open_start_q, open_start_d;
  stt_pkg::line_t open_line_q, open_line_d;
  stt_pkg::col_t  open_column_q, open_column_d;

  // Result queue
  stt_pkg::out_item_t                 fifo_q [stt_pkg::FifoDepth];
  logic [stt_pkg::PtrWidth-1:0]       wr_ptr_q, rd_ptr_q;
  logic [stt_pkg::CountWidth-1:0]     count_q, count_d;

  logic                in_fire, out_fire;
  logic [7:0]          b;
  logic                fin;
  stt_pkg::off_t       boff;
  stt_pkg::line_t      bln;
  stt_pkg::col_t       bcol;
  logic                consumed;
  logic                emit1, emit2;
  stt_pkg::off_t       end1;
  stt_pkg::out_item_t  tok1, tok2, res0, res1;
  logic [1:0]          n_push;

  function automatic stt_pkg::off_t sat_off(input stt_pkg::off_t v);
    return (v == '1) ? v : stt_pkg::off_t'(v + 1'b1);
  endfunction

  function automatic stt_pkg::line_t sat_line(input stt_pkg::line_t v);
    return (v == '1) ? v : stt_pkg::line_t'(v + 1'b1);
  endfunction

  function automatic stt_pkg::col_t sat_col(input stt_pkg::col_t v);
    return (v == '1) ? v : stt_pkg::col_t'(v + 1'b1);
  endfunction

  assign in_ready_o  = (count_q <= stt_pkg::CountWidth'(stt_pkg::FifoDepth - 2));
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign out_data_o  = fifo_q[rd_ptr_q];

  assign b   = in_data_i.text_byte;
  assign fin = in_data_i.final_byte;

  // Judge the held byte against the new one and advance the position
  always_comb begin
    held_d        = held_q;
    held_valid_d  = held_valid_q;
    drop_next_d   = drop_next_q;
    offset_d      = offset_q;
    line_d        = line_q;
    column_d      = column_q;
    open_d        = open_q;
    mode_d        = mode_q;
    open_start_d  = open_start_q;
    open_line_d   = open_line_q;
    open_column_d = open_column_q;
    consumed      = 1'b0;
    emit1         = 1'b0;
    emit2         = 1'b0;
    end1          = offset_q;
    boff          = offset_q;
    bln           = line_q;
    bcol          = column_q;

    if (held_valid_q) begin
      boff = sat_off(offset_q);
      if (stt_pkg::is_break(held_q)) begin
        bln  = sat_line(line_q);
        bcol = stt_pkg::col_t'(1);
      end else begin
        bcol = sat_col(column_q);
      end
      if (open_q) begin
        if (drop_next_q && held_q == stt_pkg::ChSlash &&
            (b == stt_pkg::ChSlash || b == stt_pkg::ChStar)) begin
          if (b == stt_pkg::ChSlash) begin
            mode_d = stt_pkg::ModeLine;
          end else begin
            mode_d   = stt_pkg::ModeBlock;
            consumed = 1'b1;
          end
        end else if (mode_q == stt_pkg::ModeLine) begin
          if (stt_pkg::is_break(b)) begin
            emit1 = 1'b1;
            end1  = offset_q;
          end
        end else if (mode_q == stt_pkg::ModeBlock) begin
          if (held_q == stt_pkg::ChStar && b == stt_pkg::ChSlash) begin
            emit1    = 1'b1;
            end1     = boff;
            consumed = 1'b1;
          end
        end else if (!stt_pkg::is_word(held_q) || !stt_pkg::is_word(b)) begin
          emit1 = 1'b1;
          end1  = offset_q;
        end
      end
      drop_next_d = 1'b0;
      if (held_q == stt_pkg::ChCr && b == stt_pkg::ChLf) begin
        consumed = 1'b1;
      end
    end

    // Close the token that ended on the held byte or, for a block comment, on the new one
    if (emit1) begin
      open_d = 1'b0;
      mode_d = stt_pkg::ModeNone;
    end

    if (consumed) begin
      held_valid_d = 1'b0;
      offset_d     = sat_off(boff);
      line_d       = bln;
      column_d     = (b == stt_pkg::ChLf) ? bcol : sat_col(bcol);
    end else begin
      offset_d = boff;
      line_d   = bln;
      column_d = bcol;
      if (!open_d && !stt_pkg::is_blank(b)) begin
        open_d        = 1'b1;
        drop_next_d   = 1'b1;
        mode_d        = stt_pkg::ModeNone;
        open_start_d  = boff;
        open_line_d   = bln;
        open_column_d = bcol;
      end
      held_d       = b;
      held_valid_d = 1'b1;
    end

    // Close any open token at end of text, then return to reset
    if (fin) begin
      emit2         = open_d;
      held_d        = '0;
      held_valid_d  = 1'b0;
      drop_next_d   = 1'b0;
      offset_d      = '0;
      line_d        = stt_pkg::line_t'(1);
      column_d      = stt_pkg::col_t'(1);
      open_d        = 1'b0;
      mode_d        = stt_pkg::ModeNone;
      open_start_d  = '0;
      open_line_d   = stt_pkg::line_t'(1);
      open_column_d = stt_pkg::col_t'(1);
    end
  end

  // Form the tokens of this beat
  always_comb begin
    tok1.token_start  = open_start_q;
    tok1.token_end    = end1;
    tok1.token_line   = open_line_q;
    tok1.token_column = open_column_q;
    tok1.run_last     = !emit2;

    tok2.token_start  = emit1 ? boff : open_start_q;
    tok2.token_end    = boff;
    tok2.token_line   = emit1 ? bln : open_line_q;
    tok2.token_column = emit1 ? bcol : open_column_q;
    tok2.run_last     = 1'b1;

    // A new token opened this beat takes the position just computed
    if (!consumed && !stt_pkg::is_blank(b) && (!open_q || emit1)) begin
      tok2.token_start  = boff;
      tok2.token_line   = bln;
      tok2.token_column = bcol;
    end

    res0 = emit1 ? tok1 : tok2;
    res1 = tok2;

    if (!in_fire) begin
      n_push = 2'd0;
    end else begin
      n_push = {1'b0, emit1} + {1'b0, emit2};
    end
  end

  assign count_d = stt_pkg::CountWidth'(count_q + n_push - out_fire);

  // Hold lexer state; advance only on an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q        <= '0;
      held_valid_q  <= 1'b0;
      drop_next_q   <= 1'b0;
      offset_q      <= '0;
      line_q        <= stt_pkg::line_t'(1);
      column_q      <= stt_pkg::col_t'(1);
      open_q        <= 1'b0;
      mode_q        <= stt_pkg::ModeNone;
      open_start_q  <= '0;
      open_line_q   <= stt_pkg::line_t'(1);
      open_column_q <= stt_pkg::col_t'(1);
    end else if (in_fire) begin
      held_q        <= held_d;
      held_valid_q  <= held_valid_d;
      drop_next_q   <= drop_next_d;
      offset_q      <= offset_d;
      line_q        <= line_d;
      column_q      <= column_d;
      open_q        <= open_d;
      mode_q        <= mode_d;
      open_start_q  <= open_start_d;
      open_line_q   <= open_line_d;
      open_column_q <= open_column_d;
    end
  end

  // Advance queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= stt_pkg::PtrWidth'(wr_ptr_q + n_push);
      if (out_fire) begin
        rd_ptr_q <= stt_pkg::PtrWidth'(rd_ptr_q + 1'b1);
      end
      count_q <= count_d;
    end
  end

  // Write up to two tokens per beat
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (n_push == 2'd2) begin
      fifo_q[stt_pkg::PtrWidth'(wr_ptr_q + 1'b1)] <= res1;
    end
  end

  `ASSERT_NEVER(a_fifo_overflow, count_q > stt_pkg::CountWidth'(stt_pkg::FifoDepth), "result queue overflow")
  `ASSERT_PROP(a_no_push_idle, !in_fire |=> count_q <= $past(count_q), "queue grew without an input beat")
  `ASSERT_PROP(a_final_clears, in_fire && fin |=> !held_valid_q && !open_q, "state not cleared after final byte")
  `ASSERT_PROP(a_mode_needs_open, mode_q != stt_pkg::ModeNone |-> open_q, "comment mode without open token")

endmodule

### tb/sv/tb_schema_text_tokenizer_top.sv
// Testbench for the streaming text tokenizer: directed and random texts, checked per token.
module tb_schema_text_tokenizer_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  stt_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  stt_pkg::out_item_t out_data_o;

  schema_text_tokenizer_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Free-running clock, 8 ns period
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Tokens the lexer mirror has produced and the block still owes
  stt_pkg::out_item_t pending_tokens[$];
  logic [7:0] text_buf[$];

  int  fail_count     = 0;
  int  tokens_checked = 0;
  int  bytes_sent     = 0;
  int  texts_sent     = 0;
  int  step_tokens;
  bit  in_idle        = 1'b1;
  bit  out_idle       = 1'b1;

  // Lexer mirror state
  logic [7:0]     la_byte;
  bit             la_valid;
  bit             fresh_token;
  stt_pkg::off_t  cur_off;
  stt_pkg::line_t cur_line;
  stt_pkg::col_t  cur_col;
  bit             tok_open;
  logic [1:0]     tok_mode;
  stt_pkg::off_t  tok_start;
  stt_pkg::line_t tok_line;
  stt_pkg::col_t  tok_col;

  localparam logic [7:0] PunctBytes [6] = '{8'h2B, 8'h2D, 8'h28, 8'h29, 8'h3B, 8'h3D};

  function automatic stt_pkg::off_t off_inc(input stt_pkg::off_t v);
    return (&v) ? v : stt_pkg::off_t'(v + 1'b1);
  endfunction

  function automatic stt_pkg::line_t line_inc(input stt_pkg::line_t v);
    return (&v) ? v : stt_pkg::line_t'(v + 1'b1);
  endfunction

  function automatic stt_pkg::col_t col_inc(input stt_pkg::col_t v);
    return (&v) ? v : stt_pkg::col_t'(v + 1'b1);
  endfunction

  function automatic bit word_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || (c == stt_pkg::ChUnder);
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return (c == stt_pkg::ChSpace) || (c == stt_pkg::ChTab) ||
           (c == stt_pkg::ChCr) || (c == stt_pkg::ChLf);
  endfunction

  // Append one byte to the text buffer
  function automatic void add_byte(input logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endfunction

  function automatic void clear_lexer();
    la_byte     = '0;
    la_valid    = 1'b0;
    fresh_token = 1'b0;
    cur_off     = '0;
    cur_line    = stt_pkg::line_t'(1);
    cur_col     = stt_pkg::col_t'(1);
    tok_open    = 1'b0;
    tok_mode    = stt_pkg::ModeNone;
    tok_start   = '0;
    tok_line    = stt_pkg::line_t'(1);
    tok_col     = stt_pkg::col_t'(1);
  endfunction

  // Close the open token on the given last offset and queue it
  function automatic void close_token(input stt_pkg::off_t last_off);
    stt_pkg::out_item_t t;
    t.token_start  = tok_start;
    t.token_end    = last_off;
    t.token_line   = tok_line;
    t.token_column = tok_col;
    t.run_last     = 1'b0;
    pending_tokens.insert(pending_tokens.size(), t);
    step_tokens++;
    tok_open = 1'b0;
    tok_mode = stt_pkg::ModeNone;
  endfunction

  // Advance the lexer mirror by one accepted byte and queue the tokens it ends
  function automatic void lex_byte(input logic [7:0] b, input logic fin);
    logic [7:0]     h;
    bit             eaten;
    stt_pkg::off_t  next_off;
    stt_pkg::line_t next_line;
    stt_pkg::col_t  next_col;
    step_tokens = 0;
    eaten       = 1'b0;
    if (la_valid) begin
      h        = la_byte;
      next_off = off_inc(cur_off);
      if (h == stt_pkg::ChCr || h == stt_pkg::ChLf) begin
        next_line = line_inc(cur_line);
        next_col  = stt_pkg::col_t'(1);
      end else begin
        next_line = cur_line;
        next_col  = col_inc(cur_col);
      end
      if (tok_open) begin
        if (fresh_token && h == stt_pkg::ChSlash &&
            (b == stt_pkg::ChSlash || b == stt_pkg::ChStar)) begin
          if (b == stt_pkg::ChSlash) begin
            tok_mode = stt_pkg::ModeLine;
          end else begin
            tok_mode = stt_pkg::ModeBlock;
            eaten    = 1'b1;
          end
        end else if (tok_mode == stt_pkg::ModeLine) begin
          if (b == stt_pkg::ChCr || b == stt_pkg::ChLf) close_token(cur_off);
        end else if (tok_mode == stt_pkg::ModeBlock) begin
          if (h == stt_pkg::ChStar && b == stt_pkg::ChSlash) begin
            close_token(next_off);
            eaten = 1'b1;
          end
        end else if (!word_char(h) || !word_char(b)) begin
          close_token(cur_off);
        end
      end
      fresh_token = 1'b0;
      // LF of a CR LF pair takes an offset but no column
      if (h == stt_pkg::ChCr && b == stt_pkg::ChLf) eaten = 1'b1;
    end else begin
      next_off  = cur_off;
      next_line = cur_line;
      next_col  = cur_col;
    end

    if (eaten) begin
      la_valid = 1'b0;
      cur_off  = off_inc(next_off);
      cur_line = next_line;
      cur_col  = (b == stt_pkg::ChLf) ? next_col : col_inc(next_col);
    end else begin
      cur_off  = next_off;
      cur_line = next_line;
      cur_col  = next_col;
      if (!tok_open && !blank_char(b)) begin
        tok_open    = 1'b1;
        fresh_token = 1'b1;
        tok_mode    = stt_pkg::ModeNone;
        tok_start   = next_off;
        tok_line    = next_line;
        tok_col     = next_col;
      end
      la_byte  = b;
      la_valid = 1'b1;
    end

    if (fin) begin
      if (tok_open) close_token(next_off);
      clear_lexer();
    end

    if (step_tokens > 0) pending_tokens[pending_tokens.size()-1].run_last = 1'b1;
  endfunction

  // Send one byte beat; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = in_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= stt_pkg::in_item_t'{text_byte: b, final_byte: fin};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    lex_byte(b, fin);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Send the text buffer with the final mark on its last byte
  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      send_byte(text_buf[i], i == text_buf.size() - 1);
    end
    texts_sent++;
  endtask

  task automatic send_string(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    send_text();
  endtask

  function automatic logic [7:0] random_word_char();
    case ($urandom_range(0, 3))
      0:       return 8'(8'h61 + $urandom_range(0, 25));
      1:       return 8'(8'h41 + $urandom_range(0, 25));
      2:       return 8'(8'h30 + $urandom_range(0, 9));
      default: return stt_pkg::ChUnder;
    endcase
  endfunction

  function automatic void push_break();
    case ($urandom_range(0, 2))
      0: add_byte(stt_pkg::ChCr);
      1: add_byte(stt_pkg::ChLf);
      default: begin
        add_byte(stt_pkg::ChCr);
        add_byte(stt_pkg::ChLf);
      end
    endcase
  endfunction

  // Build a text mostly from well-formed pieces: words, blanks, breaks, comments
  function automatic void build_random_text();
    int target;
    int len;
    text_buf.delete();
    target = $urandom_range(1, 32);
    while (text_buf.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 9: begin
          len = $urandom_range(1, 6);
          repeat (len) add_byte(random_word_char());
        end
        2: add_byte($urandom_range(0, 1) ? stt_pkg::ChSpace : stt_pkg::ChTab);
        3: push_break();
        4: begin
          add_byte(stt_pkg::ChSlash);
          add_byte(stt_pkg::ChSlash);
          len = $urandom_range(0, 5);
          repeat (len) add_byte(8'($urandom_range(8'h20, 8'h7E)));
          push_break();
        end
        5: begin
          add_byte(stt_pkg::ChSlash);
          add_byte(stt_pkg::ChStar);
          len = $urandom_range(0, 6);
          repeat (len) begin
            case ($urandom_range(0, 4))
              0: add_byte(stt_pkg::ChStar);
              1: add_byte(stt_pkg::ChSlash);
              2: add_byte(stt_pkg::ChSpace);
              3: add_byte(stt_pkg::ChLf);
              default: add_byte(random_word_char());
            endcase
          end
          add_byte(stt_pkg::ChStar);
          add_byte(stt_pkg::ChSlash);
        end
        6: add_byte(PunctBytes[3'($urandom_range(0, 5))]);
        7: add_byte(8'($urandom_range(0, 255)));
        default: add_byte($urandom_range(0, 1) ? stt_pkg::ChSlash : stt_pkg::ChStar);
      endcase
    end
  endfunction

  // Word runs, single-byte tokens, and CR and CR LF breaks
  task automatic test_words_and_breaks();
    send_string("Z_9+\015\012b\015c");
  endtask

  // Empty line comment ended by CR, then a block comment that slash-star-slash cannot close
  task automatic test_comments();
    send_string("//\015/*/*/a");
  endtask

  // Texts that end inside an unterminated comment or on a bare opener
  task automatic test_end_of_text();
    send_string("/*");
    send_string("//x");
  endtask

  // Control bytes and high bytes form single-byte tokens
  task automatic test_odd_bytes();
    text_buf.delete();
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(8'h7F);
    add_byte(8'h80);
    send_text();
  endtask

  // Random texts with idling switched on and off per text
  task automatic test_random_texts();
    int start_bytes;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < 420) begin
      in_idle  = $urandom_range(0, 3) != 0;
      out_idle = $urandom_range(0, 3) != 0;
      build_random_text();
      send_text();
    end
  endtask

  // Drive reset and run the tests in turn
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    clear_lexer();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_words_and_breaks();
    test_comments();
    test_end_of_text();
    test_odd_bytes();
    test_random_texts();

    in_valid_i <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Sent %0d texts, %0d bytes; checked %0d tokens.", texts_sent, bytes_sent,
             tokens_checked);
    $display("Covered comments, line breaks, end-of-text closes, odd bytes, random stalls.");
    if (fail_count == 0) begin
      $display("tb_schema_text_tokenizer_top: PASS");
    end else begin
      $display("tb_schema_text_tokenizer_top: FAIL");
    end
    $finish;
  end

  // Stall the result side for a random number of cycles before each beat while out_idle is set
  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = out_idle ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Compare each token beat with the oldest expected token
  always @(posedge clk_i) begin : check_tokens
    stt_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_tokens.size() == 0) begin
        $error("token beat with none expected: start %0d end %0d",
               out_data_o.token_start, out_data_o.token_end);
        fail_count++;
      end else begin
        want = pending_tokens.pop_front();
        tokens_checked++;
        if (out_data_o.token_start !== want.token_start) begin
          $error("token_start: expected %0d, got %0d", want.token_start,
                 out_data_o.token_start);
          fail_count++;
        end
        if (out_data_o.token_end !== want.token_end) begin
          $error("token_end: expected %0d, got %0d", want.token_end, out_data_o.token_end);
          fail_count++;
        end
        if (out_data_o.token_line !== want.token_line) begin
          $error("token_line: expected %0d, got %0d", want.token_line,
                 out_data_o.token_line);
          fail_count++;
        end
        if (out_data_o.token_column !== want.token_column) begin
          $error("token_column: expected %0d, got %0d", want.token_column,
                 out_data_o.token_column);
          fail_count++;
        end
        if (out_data_o.run_last !== want.run_last) begin
          $error("run_last: expected %0d, got %0d", want.run_last, out_data_o.run_last);
          fail_count++;
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    #5ms;
    $display("tb_schema_text_tokenizer_top: FAIL");
    $finish;
  end

endmodule
